### hw/rtl/tick_task_scheduler_table_assert.svh
// assertion macros for the tick task scheduler table
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef TICK_TASK_SCHEDULER_TABLE_ASSERT_SVH
`define TICK_TASK_SCHEDULER_TABLE_ASSERT_SVH
`ifndef SYNTH
`define TTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TTS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/tts_pkg.sv
// shared types and constants of the tick task scheduler table
// no dependencies
`default_nettype none
package tts_pkg;

  localparam int MAX_OUT = 8;
  localparam int CNT_W   = $clog2(MAX_OUT);
  localparam logic [15:0] TICK_RESET = 16'd50;
  localparam logic signed [33:0] DELAY_FLOOR = -34'sd2147483648;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ADD  = 2'd1,
    OP_DEL  = 2'd2,
    OP_DISP = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE = 3'd0,
    ST_FULL = 3'd1,
    ST_OOR  = 3'd2,
    ST_DUE  = 3'd3,
    ST_NONE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  typedef struct packed {
    logic [31:0] time_left;  // delay after tick, reloaded when due if the reload period is nonzero
    logic [15:0] pend_tick;  // run count after a tick
    logic [15:0] pend_disp;  // run count after a dispatch
    logic        due;
    logic        one_shot;
  } alu_res_t;

endpackage
`default_nettype wire

### hw/rtl/tts_slot_alu.sv
// shared slot update unit: delay subtract with floor, run count step, reload
// depends on tts_pkg
`default_nettype none
module tts_slot_alu (
  input  wire logic [31:0]     time_left,
  input  wire logic [15:0]     reload,
  input  wire logic [15:0]     pending,
  input  wire logic [15:0]     tick_amount,
  output tts_pkg::alu_res_t    res
);

  logic signed [33:0] diff;
  logic signed [33:0] sat;

  always_comb begin
    diff = $signed({{2{time_left[31]}}, time_left}) - $signed({18'd0, tick_amount});
    sat  = (diff < tts_pkg::DELAY_FLOOR) ? tts_pkg::DELAY_FLOOR : diff;
    res.due = sat[33] || (sat == 34'sd0);
    if (res.due && (reload != 16'd0)) begin
      res.time_left = {16'd0, reload};
    end else begin
      res.time_left = sat[31:0];
    end
    // run count saturates at the top
    if (res.due && (pending != 16'hFFFF)) begin
      res.pend_tick = pending + 16'd1;
    end else begin
      res.pend_tick = pending;
    end
    res.pend_disp = pending - 16'd1;
    res.one_shot  = (reload == 16'd0);
  end

endmodule
`default_nettype wire

### hw/rtl/tick_task_scheduler_table.sv
// Task table with NUM_SLOTS slots driven by a small sequencer that walks the slots one per
// cycle through a single shared update unit. One item is taken at a time (in_tready is high
// only when the sequencer is idle). Tick walks every slot, dispatch every slot or to its
// eighth due slot, add to the first free slot or the last, delete only the named slot.
// Dispatch reports up to eight due slots as separate beats in slot order, the final beat
// flagged by out_tlast, and its walk pauses while out_tready holds back an earlier beat.
// The slot walk through the shared unit sets the rate. The user must write tick_amount
// through cfg_wr_en and cfg_wr_data while idle; the block itself does not enforce this.
// depends on tts_pkg, tts_slot_alu and tick_task_scheduler_table_assert.svh
`default_nettype none
`include "tick_task_scheduler_table_assert.svh"
module tick_task_scheduler_table #(
  parameter int NUM_SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,   // tick_amount
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [39:0] in_tdata,      // slot[2:0], first_delay[18:3], period[34:19]
  input  wire logic [1:0]  in_tuser,      // func[1:0]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata,     // slot_out[2:0], runs_left[18:3], elapsed_ms[34:19]
  output      logic [2:0]  out_tuser,     // status[2:0]
  output      logic        out_tlast
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW    = tts_pkg::CNT_W;

  // slot table
  logic [NUM_SLOTS-1:0] used_r;
  logic [31:0]          time_mem [NUM_SLOTS];
  logic [15:0]          rel_mem  [NUM_SLOTS];
  logic [15:0]          pend_mem [NUM_SLOTS];

  tts_pkg::state_t  state_r, state_nxt;
  tts_pkg::op_t     op_r, op_nxt;
  logic [2:0]       slot_r, slot_nxt;
  logic             oor_r, oor_nxt;
  logic [15:0]      delay_r, delay_nxt;
  logic [15:0]      period_r, period_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             held_vld_r, held_vld_nxt;
  logic [2:0]       held_slot_r, held_slot_nxt;
  logic [15:0]      held_runs_r, held_runs_nxt;
  tts_pkg::status_t res_status_r, res_status_nxt;
  logic [2:0]       res_slot_r, res_slot_nxt;
  logic [15:0]      res_runs_r, res_runs_nxt;
  logic [15:0]      elapsed_r, elapsed_nxt;
  logic [15:0]      tick_r;

  logic             out_valid_r, out_valid_nxt;
  tts_pkg::status_t out_status_r, out_status_nxt;
  logic [2:0]       out_slot_r, out_slot_nxt;
  logic [15:0]      out_runs_r, out_runs_nxt;
  logic [15:0]      out_elapsed_r, out_elapsed_nxt;
  logic             out_last_r, out_last_nxt;

  // table write port, always at idx_r
  logic             we_time, we_rel, we_pend, we_used;
  logic [31:0]      wd_time;
  logic [15:0]      wd_rel, wd_pend;
  logic             wd_used;

  logic             accept, out_free, last_idx, cur_used, fin_st;
  logic [15:0]      pend_eff;
  tts_pkg::alu_res_t alu;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign last_idx = (idx_r == IDX_W'(NUM_SLOTS - 1));
  assign cur_used = used_r[idx_r];
  assign pend_eff = cur_used ? pend_mem[idx_r] : 16'd0;
  assign fin_st   = (state_r == tts_pkg::S_FIN);

  tts_slot_alu u_alu (
    .time_left   (time_mem[idx_r]),
    .reload      (rel_mem[idx_r]),
    .pending     (pend_eff),
    .tick_amount (tick_r),
    .res         (alu)
  );

  assign in_tready  = (state_r == tts_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_elapsed_r, out_runs_r, out_slot_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    slot_nxt        = slot_r;
    oor_nxt         = oor_r;
    delay_nxt       = delay_r;
    period_nxt      = period_r;
    idx_nxt         = idx_r;
    cnt_nxt         = cnt_r;
    held_vld_nxt    = held_vld_r;
    held_slot_nxt   = held_slot_r;
    held_runs_nxt   = held_runs_r;
    res_status_nxt  = res_status_r;
    res_slot_nxt    = res_slot_r;
    res_runs_nxt    = res_runs_r;
    elapsed_nxt     = elapsed_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_runs_nxt    = out_runs_r;
    out_elapsed_nxt = out_elapsed_r;
    out_last_nxt    = out_last_r;
    we_time = 1'b0;
    we_rel  = 1'b0;
    we_pend = 1'b0;
    we_used = 1'b0;
    wd_time = alu.time_left;
    wd_rel  = period_r;
    wd_pend = alu.pend_tick;
    wd_used = 1'b0;

    unique case (state_r)
      tts_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt       = tts_pkg::op_t'(in_tuser);
          slot_nxt     = in_tdata[2:0];
          oor_nxt      = ({29'd0, in_tdata[2:0]} >= 32'(NUM_SLOTS));
          delay_nxt    = in_tdata[18:3];
          period_nxt   = in_tdata[34:19];
          idx_nxt      = (tts_pkg::op_t'(in_tuser) == tts_pkg::OP_DEL) ?
                         IDX_W'(in_tdata[2:0]) : '0;
          cnt_nxt      = '0;
          held_vld_nxt = 1'b0;
          if (tts_pkg::op_t'(in_tuser) == tts_pkg::OP_TICK) begin
            elapsed_nxt = elapsed_r + tick_r;
          end
          state_nxt = tts_pkg::S_WALK;
        end
      end

      tts_pkg::S_WALK: begin
        unique case (op_r)
          tts_pkg::OP_TICK: begin
            if (cur_used) begin
              we_time = 1'b1;
              we_pend = 1'b1;
            end
            if (last_idx) begin
              res_status_nxt = tts_pkg::ST_DONE;
              res_slot_nxt   = 3'd0;
              res_runs_nxt   = 16'd0;
              state_nxt      = tts_pkg::S_FIN;
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end

          tts_pkg::OP_ADD: begin
            res_runs_nxt = 16'd0;
            if (!cur_used) begin
              we_used        = 1'b1;
              wd_used        = 1'b1;
              we_time        = 1'b1;
              wd_time        = {16'd0, delay_r};
              we_rel         = 1'b1;
              we_pend        = 1'b1;
              wd_pend        = 16'd0;
              res_status_nxt = tts_pkg::ST_DONE;
              res_slot_nxt   = 3'(idx_r);
              state_nxt      = tts_pkg::S_FIN;
            end else if (last_idx) begin
              res_status_nxt = tts_pkg::ST_FULL;
              res_slot_nxt   = 3'd0;
              state_nxt      = tts_pkg::S_FIN;
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end

          tts_pkg::OP_DEL: begin
            res_slot_nxt = slot_r;
            res_runs_nxt = 16'd0;
            if (oor_r) begin
              res_status_nxt = tts_pkg::ST_OOR;
            end else begin
              // a freed slot reads as zero runs, the rest is rewritten by add
              we_used        = 1'b1;
              wd_used        = 1'b0;
              res_status_nxt = tts_pkg::ST_DONE;
            end
            state_nxt = tts_pkg::S_FIN;
          end

          tts_pkg::OP_DISP: begin
            if (pend_eff != 16'd0) begin
              // hold the walk while the previous due beat cannot move out
              if (!(held_vld_r && !out_free)) begin
                we_pend = 1'b1;
                wd_pend = alu.pend_disp;
                if (alu.one_shot) begin
                  we_used = 1'b1;
                  wd_used = 1'b0;
                end
                if (held_vld_r) begin
                  out_valid_nxt   = 1'b1;
                  out_status_nxt  = tts_pkg::ST_DUE;
                  out_slot_nxt    = held_slot_r;
                  out_runs_nxt    = held_runs_r;
                  out_elapsed_nxt = elapsed_r;
                  out_last_nxt    = 1'b0;
                end
                cnt_nxt = cnt_r + CW'(1);
                if (last_idx || (cnt_r == CW'(tts_pkg::MAX_OUT - 1))) begin
                  held_vld_nxt   = 1'b0;
                  res_status_nxt = tts_pkg::ST_DUE;
                  res_slot_nxt   = 3'(idx_r);
                  res_runs_nxt   = alu.pend_disp;
                  state_nxt      = tts_pkg::S_FIN;
                end else begin
                  held_vld_nxt  = 1'b1;
                  held_slot_nxt = 3'(idx_r);
                  held_runs_nxt = alu.pend_disp;
                  idx_nxt       = idx_r + IDX_W'(1);
                end
              end
            end else if (last_idx) begin
              if (held_vld_r) begin
                res_status_nxt = tts_pkg::ST_DUE;
                res_slot_nxt   = held_slot_r;
                res_runs_nxt   = held_runs_r;
              end else begin
                res_status_nxt = tts_pkg::ST_NONE;
                res_slot_nxt   = 3'd0;
                res_runs_nxt   = 16'd0;
              end
              held_vld_nxt = 1'b0;
              state_nxt    = tts_pkg::S_FIN;
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end

          default: begin
            state_nxt = tts_pkg::S_IDLE;
          end
        endcase
      end

      tts_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_slot_nxt    = res_slot_r;
          out_runs_nxt    = res_runs_r;
          out_elapsed_nxt = elapsed_r;
          out_last_nxt    = 1'b1;
          state_nxt       = tts_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = tts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tts_pkg::S_IDLE;
      used_r      <= '0;
      elapsed_r   <= 16'd0;
      tick_r      <= tts_pkg::TICK_RESET;
      held_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      elapsed_r   <= elapsed_nxt;
      held_vld_r  <= held_vld_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (we_used) begin
        used_r[idx_r] <= wd_used;
      end
      if (cfg_wr_en) begin
        tick_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    slot_r        <= slot_nxt;
    oor_r         <= oor_nxt;
    delay_r       <= delay_nxt;
    period_r      <= period_nxt;
    idx_r         <= idx_nxt;
    held_slot_r   <= held_slot_nxt;
    held_runs_r   <= held_runs_nxt;
    res_status_r  <= res_status_nxt;
    res_slot_r    <= res_slot_nxt;
    res_runs_r    <= res_runs_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_runs_r    <= out_runs_nxt;
    out_elapsed_r <= out_elapsed_nxt;
    out_last_r    <= out_last_nxt;
    if (we_time) begin
      time_mem[idx_r] <= wd_time;
    end
    if (we_rel) begin
      rel_mem[idx_r] <= wd_rel;
    end
    if (we_pend) begin
      pend_mem[idx_r] <= wd_pend;
    end
  end

  `TTS_ASSERT(a_busy_after_accept, clk, rst_n, accept |=> !in_tready, "ready after accept")
  `TTS_ASSERT(a_held_disp, clk, rst_n, held_vld_r |-> (op_r == tts_pkg::OP_DISP), "held beat")
  `TTS_ASSERT(a_fin_hold, clk, rst_n, fin_st && !out_free |=> fin_st, "final beat dropped")
  `TTS_ASSERT_ALWAYS(a_reset_no_out, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule
`default_nettype wire

### sim/tb_tick_task_scheduler_table.sv
// self-checking testbench for tick_task_scheduler_table: directed table, random phases
// and a short run at the largest tick, all checked beat by beat against a behavioral table
// depends on tts_pkg and the tick_task_scheduler_table rtl
`timescale 1ns / 1ps
module tb_tick_task_scheduler_table;

  localparam int NUM_SLOTS  = 8;
  localparam int SETTLE     = 24;
  localparam int PHASES     = 6;
  localparam int PHASE_LEN  = 72;
  localparam int SAT_TICKS  = 16;
  localparam int PLAN_LEN   = 24;

  typedef struct packed {
    tts_pkg::status_t status;
    logic [2:0]       slot;
    logic [15:0]      runs;
    logic [15:0]      elapsed;
    logic             last;
  } res_t;

  typedef struct packed {
    tts_pkg::op_t func;
    logic [2:0]   slot;
    logic [15:0]  delay;
    logic [15:0]  period;
    logic         typed;
    res_t         want;
  } row_t;

  // rows with a typed result carry only single-beat operations
  localparam row_t PLAN [PLAN_LEN] = '{
    '{tts_pkg::OP_DISP, 3'd0, 16'd0,     16'd0,     1'b1,
      '{tts_pkg::ST_NONE, 3'd0, 16'd0, 16'd0,   1'b1}},
    '{tts_pkg::OP_DEL,  3'd7, 16'd0,     16'd0,     1'b1,
      '{tts_pkg::ST_DONE, 3'd7, 16'd0, 16'd0,   1'b1}},
    '{tts_pkg::OP_TICK, 3'd0, 16'd0,     16'd0,     1'b1,
      '{tts_pkg::ST_DONE, 3'd0, 16'd0, 16'd50,  1'b1}},
    '{tts_pkg::OP_ADD,  3'd0, 16'd0,     16'd0,     1'b1,
      '{tts_pkg::ST_DONE, 3'd0, 16'd0, 16'd50,  1'b1}},
    '{tts_pkg::OP_ADD,  3'd7, 16'hFFFF,  16'hFFFF,  1'b1,
      '{tts_pkg::ST_DONE, 3'd1, 16'd0, 16'd50,  1'b1}},
    '{tts_pkg::OP_ADD,  3'd0, 16'd100,   16'd50,    1'b1,
      '{tts_pkg::ST_DONE, 3'd2, 16'd0, 16'd50,  1'b1}},
    '{tts_pkg::OP_ADD,  3'd0, 16'd1,     16'd0,     1'b1,
      '{tts_pkg::ST_DONE, 3'd3, 16'd0, 16'd50,  1'b1}},
    '{tts_pkg::OP_ADD,  3'd0, 16'd50,    16'd1,     1'b1,
      '{tts_pkg::ST_DONE, 3'd4, 16'd0, 16'd50,  1'b1}},
    '{tts_pkg::OP_ADD,  3'd0, 16'd0,     16'hFFFF,  1'b1,
      '{tts_pkg::ST_DONE, 3'd5, 16'd0, 16'd50,  1'b1}},
    '{tts_pkg::OP_ADD,  3'd0, 16'd40000, 16'd0,     1'b1,
      '{tts_pkg::ST_DONE, 3'd6, 16'd0, 16'd50,  1'b1}},
    '{tts_pkg::OP_ADD,  3'd0, 16'd200,   16'd100,   1'b1,
      '{tts_pkg::ST_DONE, 3'd7, 16'd0, 16'd50,  1'b1}},
    '{tts_pkg::OP_ADD,  3'd0, 16'd5,     16'd5,     1'b1,
      '{tts_pkg::ST_FULL, 3'd0, 16'd0, 16'd50,  1'b1}},
    '{tts_pkg::OP_TICK, 3'd0, 16'd0,     16'd0,     1'b0, '0},
    '{tts_pkg::OP_TICK, 3'd0, 16'd0,     16'd0,     1'b0, '0},
    '{tts_pkg::OP_DISP, 3'd0, 16'd0,     16'd0,     1'b0, '0},
    '{tts_pkg::OP_TICK, 3'd0, 16'd0,     16'd0,     1'b0, '0},
    '{tts_pkg::OP_TICK, 3'd0, 16'd0,     16'd0,     1'b0, '0},
    '{tts_pkg::OP_DISP, 3'd0, 16'd0,     16'd0,     1'b0, '0},
    '{tts_pkg::OP_DEL,  3'd1, 16'd0,     16'd0,     1'b1,
      '{tts_pkg::ST_DONE, 3'd1, 16'd0, 16'd250, 1'b1}},
    '{tts_pkg::OP_ADD,  3'd0, 16'd123,   16'd0,     1'b0, '0},
    '{tts_pkg::OP_DISP, 3'd0, 16'd0,     16'd0,     1'b0, '0},
    '{tts_pkg::OP_DEL,  3'd5, 16'd0,     16'd0,     1'b0, '0},
    '{tts_pkg::OP_TICK, 3'd0, 16'd0,     16'd0,     1'b0, '0},
    '{tts_pkg::OP_DISP, 3'd0, 16'd0,     16'd0,     1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic [39:0] in_tdata = '0;     // slot[2:0], first_delay[18:3], period[34:19]
  logic [1:0]  in_tuser = '0;     // func[1:0]
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [39:0] out_tdata;         // slot_out[2:0], runs_left[18:3], elapsed_ms[34:19]
  wire  [2:0]  out_tuser;         // status[2:0]
  wire         out_tlast;

  // task table as the block should hold it
  logic               slot_busy [NUM_SLOTS];
  logic signed [31:0] delay_ms  [NUM_SLOTS];
  logic [15:0]        reload_ms [NUM_SLOTS];
  logic [15:0]        runs_due  [NUM_SLOTS];
  logic [15:0]        clock_ms;
  logic [15:0]        tick_ms;
  res_t               owed_beats [$];

  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   errors = 0;
  res_t got_want;

  tick_task_scheduler_table #(.NUM_SLOTS(NUM_SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL tick_task_scheduler_table");
    $finish;
  end

  task automatic note_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void owe(tts_pkg::status_t st, logic [2:0] sl, logic [15:0] rn,
                              logic lst);
    res_t r;
    r.status  = st;
    r.slot    = sl;
    r.runs    = rn;
    r.elapsed = clock_ms;
    r.last    = lst;
    owed_beats.push_back(r);
  endfunction

  function automatic void clear_task(int i);
    slot_busy[i] = 1'b0;
    delay_ms[i]  = '0;
    reload_ms[i] = '0;
    runs_due[i]  = '0;
  endfunction

  // apply one accepted item to the table and queue the beats it should produce
  function automatic void sched_step(tts_pkg::op_t f, logic [2:0] s, logic [15:0] d,
                                     logic [15:0] p);
    int     i;
    int     hit;
    longint t;
    res_t   r;
    case (f)
      tts_pkg::OP_TICK: begin
        clock_ms = clock_ms + tick_ms;
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (slot_busy[i]) begin
            t = longint'(delay_ms[i]) - longint'(tick_ms);
            if (t < longint'(tts_pkg::DELAY_FLOOR)) t = longint'(tts_pkg::DELAY_FLOOR);
            delay_ms[i] = t[31:0];
            if (t <= 0) begin
              if (runs_due[i] != 16'hFFFF) runs_due[i]++;
              if (reload_ms[i] != 0) delay_ms[i] = {16'd0, reload_ms[i]};
            end
          end
        end
        owe(tts_pkg::ST_DONE, 3'd0, 16'd0, 1'b1);
      end
      tts_pkg::OP_ADD: begin
        hit = -1;
        for (i = NUM_SLOTS - 1; i >= 0; i--)
          if (!slot_busy[i]) hit = i;
        if (hit < 0) begin
          owe(tts_pkg::ST_FULL, 3'd0, 16'd0, 1'b1);
        end else begin
          slot_busy[hit] = 1'b1;
          delay_ms[hit]  = {16'd0, d};
          reload_ms[hit] = p;
          runs_due[hit]  = '0;
          owe(tts_pkg::ST_DONE, hit[2:0], 16'd0, 1'b1);
        end
      end
      tts_pkg::OP_DEL: begin
        if (s >= NUM_SLOTS) begin
          owe(tts_pkg::ST_OOR, s, 16'd0, 1'b1);
        end else begin
          clear_task(int'(s));
          owe(tts_pkg::ST_DONE, s, 16'd0, 1'b1);
        end
      end
      default: begin
        hit = 0;
        for (i = 0; i < NUM_SLOTS && hit < tts_pkg::MAX_OUT; i++) begin
          if (runs_due[i] != 0) begin
            runs_due[i]--;
            owe(tts_pkg::ST_DUE, i[2:0], runs_due[i], 1'b0);
            hit++;
            if (reload_ms[i] == 0) clear_task(i);
          end
        end
        if (hit == 0) begin
          owe(tts_pkg::ST_NONE, 3'd0, 16'd0, 1'b1);
        end else begin
          r = owed_beats.pop_back();
          r.last = 1'b1;
          owed_beats.push_back(r);
        end
      end
    endcase
  endfunction

  task automatic send_item(tts_pkg::op_t f, logic [2:0] s, logic [15:0] d, logic [15:0] p);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {5'd0, p, d, s};
    do @(posedge clk); while (!in_tready);
    sched_step(f, s, d, p);
  endtask

  // delays mostly within a few ticks so tasks come due, with the extremes mixed in
  function automatic logic [15:0] pick_ms();
    int span;
    span = (tick_ms == 0) ? 8 : 4 * int'(tick_ms);
    if (span > 65535) span = 65535;
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(65535));
      default: return 16'($urandom_range(span));
    endcase
  endfunction

  task automatic send_random();
    int          pick;
    logic [2:0]  s;
    logic [15:0] d;
    logic [15:0] p;
    pick = $urandom_range(99);
    s = 3'($urandom_range(7));
    d = pick_ms();
    p = ($urandom_range(9) < 3) ? 16'd0 : pick_ms();
    if (pick < 35)      send_item(tts_pkg::OP_TICK, s, d, p);
    else if (pick < 60) send_item(tts_pkg::OP_ADD, s, d, p);
    else if (pick < 82) send_item(tts_pkg::OP_DISP, s, d, p);
    else                send_item(tts_pkg::OP_DEL, s, d, p);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_tick(logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tick_ms = v;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_beats.size() == 0) begin
        note_mismatch("beat with nothing owed", {13'd0, out_tuser}, 16'd0);
      end else begin
        got_want = owed_beats.pop_front();
        if (out_tuser !== got_want.status)
          note_mismatch("status", {13'd0, out_tuser}, {13'd0, got_want.status});
        if (out_tdata[2:0] !== got_want.slot)
          note_mismatch("slot_out", {13'd0, out_tdata[2:0]}, {13'd0, got_want.slot});
        if (out_tdata[18:3] !== got_want.runs)
          note_mismatch("runs_left", out_tdata[18:3], got_want.runs);
        if (out_tdata[34:19] !== got_want.elapsed)
          note_mismatch("elapsed_ms", out_tdata[34:19], got_want.elapsed);
        if (out_tlast !== got_want.last)
          note_mismatch("last", {15'd0, out_tlast}, {15'd0, got_want.last});
      end
    end
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    int ph;
    int k;
    logic [15:0] v;
    for (k = 0; k < NUM_SLOTS; k++) clear_task(k);
    clock_ms = '0;
    tick_ms  = tts_pkg::TICK_RESET;
    tx_idle_pct = 14;
    rx_idle_pct = 67;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < PLAN_LEN; k++) begin
      send_item(PLAN[k].func, PLAN[k].slot, PLAN[k].delay, PLAN[k].period);
      if (PLAN[k].typed) owed_beats[owed_beats.size() - 1] = PLAN[k].want;
    end

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0:       v = 16'd1;
        1:       v = 16'hFFFF;
        2:       v = 16'd0;
        3:       v = 16'd300;
        4:       v = 16'($urandom_range(1, 65535));
        default: v = tts_pkg::TICK_RESET;
      endcase
      write_tick(v);
      tx_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 67 : 0;
      rx_idle_pct = (ph < 2) ? 67 : (ph < 4) ? 14 : 0;
      for (k = 0; k < PHASE_LEN; k++) send_random();
    end

    // short run at the largest tick: overdue one-shot and reload-every-tick tasks pile up runs
    drain();
    write_tick(16'hFFFF);
    for (k = 0; k < NUM_SLOTS; k++) send_item(tts_pkg::OP_DEL, k[2:0], 16'd0, 16'd0);
    send_item(tts_pkg::OP_ADD, 3'd0, 16'd0, 16'd0);
    send_item(tts_pkg::OP_ADD, 3'd0, 16'd0, 16'hFFFF);
    for (k = 0; k < SAT_TICKS; k++) send_item(tts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0);
    send_item(tts_pkg::OP_DISP, 3'd0, 16'd0, 16'd0);
    send_item(tts_pkg::OP_DISP, 3'd0, 16'd0, 16'd0);
    drain();

    if (errors == 0) begin
      $display("PASS tick_task_scheduler_table");
    end else begin
      $display("FAIL tick_task_scheduler_table");
    end
    $finish;
  end

endmodule
